/* hdl/tpd_pkg.sv */
`timescale 1ns / 1ps

package tpd_pkg;

    localparam int COORD_W          = 24;
    localparam int TOL_W            = 23;
    localparam int ID_W             = 10;
    localparam int ID_PAD_W         = 16;
    localparam int LIM_W            = 2 * TOL_W;
    localparam int SQ_W             = 2 * COORD_W;
    localparam int SUM_W            = SQ_W + 1;
    localparam int COORD_FRAC_BITS  = 16;
    localparam int DEFAULT_MAX_NODES = 1024;

    // Weld radius after reset: about 1.0e-3 in the coordinate format.
    localparam logic [TOL_W-1:0] TOL_RESET =
        TOL_W'(((64'd1 << COORD_FRAC_BITS) + 64'd500) / 64'd1000);

    typedef struct packed {
        logic busy;
        logic res_valid;
        logic res_hit;
    } dist_stat_t;

endpackage

/* hdl/tolerant_point_dedup_top.sv */
// Point welding by distance: each input beat carries one 2D point (Q7.16) and gets back
// one beat with a node number. The stored unique points are searched from the newest to
// the oldest, and the first one closer than tol_radius (squared distance strictly below
// tol_radius squared) gives its table index; otherwise the point is stored under the next
// index with is_new set, or, when MAX_NODES points are already stored, table_full is set
// and node_id is 0. A set restart bit empties the table before its point is handled. The
// time from acceptance to result grows with the number of stored points searched, and a
// match cuts the search short. The point table is a single memory read one entry per cycle
// through a registered read port; the distance unit behind it registers the absolute
// differences, the squares and the compare in turn, and the control then waits for the
// pipeline to empty before it loads the result. A result that the sink has not yet taken
// holds the next one back. No reset pass is needed; the table is tracked by its fill
// count.
`timescale 1ns / 1ps

module tolerant_point_dedup_top #(
    parameter int MAX_NODES = tpd_pkg::DEFAULT_MAX_NODES
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [tpd_pkg::TOL_W-1:0]         cfg_data,    // tol_radius
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [2*tpd_pkg::COORD_W-1:0]     s_tdata,     // coord_x, coord_y
    input  logic                              s_tuser,     // restart
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [tpd_pkg::ID_PAD_W-1:0]      m_tdata,     // node_id, zero pad
    output logic [1:0]                        m_tuser      // is_new, table_full
);
    import tpd_pkg::*;

    localparam int ADDR_W = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
    localparam int CNT_W  = $clog2(MAX_NODES + 1);

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_SCAN   = 2'd1;
    localparam logic [1:0] ST_FINISH = 2'd2;

    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(MAX_NODES);

    logic [1:0]          state_reg;
    logic [1:0]          state_next;
    logic [CNT_W-1:0]    count_reg;
    logic [CNT_W-1:0]    count_next;
    logic [CNT_W-1:0]    issue_reg;
    logic [CNT_W-1:0]    issue_next;
    logic [CNT_W-1:0]    issue_dec;
    logic                found_reg;
    logic                found_next;
    logic [ADDR_W-1:0]   found_idx_reg;
    logic                rdv_reg;
    logic [ADDR_W-1:0]   rd_idx_reg;
    logic [COORD_W-1:0]  px_reg;
    logic [COORD_W-1:0]  py_reg;
    logic [TOL_W-1:0]    tol_reg;
    logic                m_valid_reg;
    logic                m_valid_next;
    logic [ID_W-1:0]     m_id_reg;
    logic [ID_W-1:0]     m_id_next;
    logic                m_new_reg;
    logic                m_new_next;
    logic                m_full_reg;
    logic                m_full_next;

    logic                accept;
    logic                hit_now;
    logic                issue;
    logic                drained;
    logic                out_free;
    logic                finish_go;
    logic                is_full;
    logic                wr_en;
    logic [ADDR_W-1:0]   rd_addr;
    logic [2*COORD_W-1:0] rd_data;
    dist_stat_t          stat;
    logic [ADDR_W-1:0]   res_idx;

    assign cfg_ready = 1'b1;
    assign s_tready  = (state_reg == ST_IDLE);
    assign accept    = s_tvalid & s_tready;

    assign hit_now   = stat.res_valid & stat.res_hit & ~found_reg;
    assign issue     = (state_reg == ST_SCAN) && (issue_reg != '0) && !found_reg && !hit_now;
    assign issue_dec = issue_reg - CNT_W'(1);
    assign rd_addr   = issue_dec[ADDR_W-1:0];
    assign drained   = !rdv_reg && !stat.busy;

    assign out_free  = !m_valid_reg || m_tready;
    assign finish_go = (state_reg == ST_FINISH) && out_free;
    assign is_full   = (count_reg == CNT_FULL);
    assign wr_en     = finish_go && !found_reg && !is_full;

    tpd_mem #(
        .DEPTH  (MAX_NODES),
        .ADDR_W (ADDR_W)
    ) u_mem (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (count_reg[ADDR_W-1:0]),
        .wr_data ({py_reg, px_reg}),
        .rd_en   (issue),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    tpd_dist #(
        .IDX_W (ADDR_W)
    ) u_dist (
        .clk      (clk),
        .rst_n    (rst_n),
        .tol      (tol_reg),
        .in_valid (rdv_reg),
        .in_idx   (rd_idx_reg),
        .px       (px_reg),
        .py       (py_reg),
        .sx       (rd_data[COORD_W-1:0]),
        .sy       (rd_data[2*COORD_W-1:COORD_W]),
        .stat     (stat),
        .res_idx  (res_idx)
    );

    always_comb
    begin
        state_next   = state_reg;
        count_next   = count_reg;
        issue_next   = issue_reg;
        found_next   = found_reg;
        m_valid_next = m_valid_reg && !m_tready;
        m_id_next    = m_id_reg;
        m_new_next   = m_new_reg;
        m_full_next  = m_full_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    count_next = s_tuser ? '0 : count_reg;
                    issue_next = s_tuser ? '0 : count_reg;
                    found_next = 1'b0;
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (issue)
                begin
                    issue_next = issue_dec;
                end
                if (hit_now)
                begin
                    found_next = 1'b1;
                end
                // Later results still in flight are dropped once the newest match is found.
                if (((issue_reg == '0) || found_reg) && drained)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (out_free)
                begin
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                    if (found_reg)
                    begin
                        m_id_next   = ID_W'(found_idx_reg);
                        m_new_next  = 1'b0;
                        m_full_next = 1'b0;
                    end
                    else if (is_full)
                    begin
                        m_id_next   = '0;
                        m_new_next  = 1'b0;
                        m_full_next = 1'b1;
                    end
                    else
                    begin
                        m_id_next   = ID_W'(count_reg);
                        m_new_next  = 1'b1;
                        m_full_next = 1'b0;
                        count_next  = count_reg + CNT_W'(1);
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            issue_reg   <= '0;
            found_reg   <= 1'b0;
            rdv_reg     <= 1'b0;
            m_valid_reg <= 1'b0;
            tol_reg     <= TOL_RESET;
        end
        else
        begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            issue_reg   <= issue_next;
            found_reg   <= found_next;
            rdv_reg     <= issue;
            m_valid_reg <= m_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                tol_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        rd_idx_reg <= rd_addr;
        m_id_reg   <= m_id_next;
        m_new_reg  <= m_new_next;
        m_full_reg <= m_full_next;
        if (hit_now)
        begin
            found_idx_reg <= res_idx;
        end
        if (accept)
        begin
            px_reg <= s_tdata[COORD_W-1:0];
            py_reg <= s_tdata[2*COORD_W-1:COORD_W];
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{(ID_PAD_W-ID_W){1'b0}}, m_id_reg};
    assign m_tuser  = {m_full_reg, m_new_reg};

endmodule

/* hdl/tpd_mem.sv */
`timescale 1ns / 1ps

module tpd_mem #(
    parameter int DEPTH  = tpd_pkg::DEFAULT_MAX_NODES,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic                          clk,
    input  logic                          wr_en,
    input  logic [ADDR_W-1:0]             wr_addr,
    input  logic [2*tpd_pkg::COORD_W-1:0] wr_data,
    input  logic                          rd_en,
    input  logic [ADDR_W-1:0]             rd_addr,
    output logic [2*tpd_pkg::COORD_W-1:0] rd_data
);
    import tpd_pkg::*;

    logic [2*COORD_W-1:0] ram_reg [DEPTH];
    logic [2*COORD_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            ram_reg[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= ram_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

/* hdl/tpd_dist.sv */
`timescale 1ns / 1ps

module tpd_dist #(
    parameter int IDX_W = 10
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [tpd_pkg::TOL_W-1:0]     tol,
    input  logic                          in_valid,
    input  logic [IDX_W-1:0]              in_idx,
    input  logic [tpd_pkg::COORD_W-1:0]   px,
    input  logic [tpd_pkg::COORD_W-1:0]   py,
    input  logic [tpd_pkg::COORD_W-1:0]   sx,
    input  logic [tpd_pkg::COORD_W-1:0]   sy,
    output tpd_pkg::dist_stat_t           stat,
    output logic [IDX_W-1:0]              res_idx
);
    import tpd_pkg::*;

    logic [LIM_W-1:0]   lim_reg;
    logic [LIM_W-1:0]   lim_next;
    logic [COORD_W:0]   dx;
    logic [COORD_W:0]   dy;
    logic [COORD_W:0]   ndx;
    logic [COORD_W:0]   ndy;
    logic [COORD_W-1:0] adx_next;
    logic [COORD_W-1:0] ady_next;
    logic [COORD_W-1:0] adx_reg;
    logic [COORD_W-1:0] ady_reg;
    logic [SQ_W-1:0]    sqx_next;
    logic [SQ_W-1:0]    sqy_next;
    logic [SQ_W-1:0]    sqx_reg;
    logic [SQ_W-1:0]    sqy_reg;
    logic [SUM_W-1:0]   sum_next;
    logic               hit_next;
    logic               hit_reg;
    logic               v1_reg;
    logic               v2_reg;
    logic               v3_reg;
    logic [IDX_W-1:0]   idx1_reg;
    logic [IDX_W-1:0]   idx2_reg;
    logic [IDX_W-1:0]   idx3_reg;

    assign lim_next = tol * tol;

    // Differences are formed one bit wider; the magnitude always fits the coordinate width.
    assign dx       = {px[COORD_W-1], px} - {sx[COORD_W-1], sx};
    assign dy       = {py[COORD_W-1], py} - {sy[COORD_W-1], sy};
    assign ndx      = -dx;
    assign ndy      = -dy;
    assign adx_next = dx[COORD_W] ? ndx[COORD_W-1:0] : dx[COORD_W-1:0];
    assign ady_next = dy[COORD_W] ? ndy[COORD_W-1:0] : dy[COORD_W-1:0];

    assign sqx_next = adx_reg * adx_reg;
    assign sqy_next = ady_reg * ady_reg;

    assign sum_next = {1'b0, sqx_reg} + {1'b0, sqy_reg};
    assign hit_next = sum_next < {{(SUM_W-LIM_W){1'b0}}, lim_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        lim_reg  <= lim_next;
        adx_reg  <= adx_next;
        ady_reg  <= ady_next;
        idx1_reg <= in_idx;
        sqx_reg  <= sqx_next;
        sqy_reg  <= sqy_next;
        idx2_reg <= idx1_reg;
        hit_reg  <= hit_next;
        idx3_reg <= idx2_reg;
    end

    assign stat.busy      = v1_reg | v2_reg | v3_reg;
    assign stat.res_valid = v3_reg;
    assign stat.res_hit   = hit_reg;
    assign res_idx        = idx3_reg;

endmodule

/* tb/sv/tb_tolerant_point_dedup_top.sv */
`timescale 1ns / 1ps

module tb_tolerant_point_dedup_top;

    import tpd_pkg::*;

    localparam int NODE_CAP = DEFAULT_MAX_NODES;
    // Weld radius after reset: 1.0e-3 in Q7.16, rounded to nearest.
    localparam logic [TOL_W-1:0] RADIUS_AT_RESET = 23'd66;
    localparam logic [TOL_W-1:0] RADIUS_MAX = '1;
    localparam logic [COORD_W-1:0] C_MAX = 24'h7FFFFF;
    localparam logic [COORD_W-1:0] C_MIN = 24'h800000;
    localparam int QUIET_LIMIT = 8000;
    localparam int DRAIN_CYCLES = NODE_CAP + 64;
    localparam int RANDOM_PHASES = 6;
    localparam int PHASE_POINTS = 92;
    localparam int HIST_DEPTH = 32;

    typedef struct {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic                      restart;
    } point_t;

    typedef struct {
        logic [ID_W-1:0] node_id;
        logic            is_new;
        logic            table_full;
    } weld_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [TOL_W-1:0]       cfg_data = '0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [2*COORD_W-1:0]   s_tdata = '0;      // coord_x, coord_y
    logic                   s_tuser = 1'b0;    // restart
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [ID_PAD_W-1:0]    m_tdata;           // node_id, zero pad
    logic [1:0]             m_tuser;           // is_new, table_full

    // Predicted state of the block.
    logic signed [COORD_W-1:0] mesh_x [NODE_CAP];
    logic signed [COORD_W-1:0] mesh_y [NODE_CAP];
    int                        mesh_count = 0;
    logic [TOL_W-1:0]          radius = RADIUS_AT_RESET;

    point_t point_q[$];
    weld_t  node_q[$];
    point_t bus_pt;
    weld_t  want;

    point_t hist [HIST_DEPTH];
    int     hist_n = 0;
    int     hist_wr = 0;
    int     since_restart = 0;

    bit     idle_en = 1'b1;
    int     send_gap = 0;
    int     stall_cnt = 0;
    int     quiet = 0;
    int     errors = 0;

    tolerant_point_dedup_top #(
        .MAX_NODES (NODE_CAP)
    ) u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Searches the stored points newest first and updates the table.
    function automatic weld_t weld_point(point_t p);
        weld_t  r;
        longint lim;
        longint dx;
        longint dy;
        int     k;
        lim = longint'(radius) * longint'(radius);
        if (p.restart)
            mesh_count = 0;
        for (k = mesh_count - 1; k >= 0; k--)
        begin
            dx = longint'(p.x) - longint'(mesh_x[k]);
            dy = longint'(p.y) - longint'(mesh_y[k]);
            if (dx * dx + dy * dy < lim)
            begin
                r.node_id = ID_W'(k);
                r.is_new = 1'b0;
                r.table_full = 1'b0;
                return r;
            end
        end
        if (mesh_count >= NODE_CAP)
        begin
            r.node_id = '0;
            r.is_new = 1'b0;
            r.table_full = 1'b1;
        end
        else
        begin
            mesh_x[mesh_count] = p.x;
            mesh_y[mesh_count] = p.y;
            r.node_id = ID_W'(mesh_count);
            r.is_new = 1'b1;
            r.table_full = 1'b0;
            mesh_count++;
        end
        return r;
    endfunction

    task automatic queue_point(point_t p);
        point_q.push_back(p);
        hist[hist_wr] = p;
        hist_wr = (hist_wr + 1) % HIST_DEPTH;
        if (hist_n < HIST_DEPTH)
            hist_n++;
        since_restart = p.restart ? 1 : since_restart + 1;
    endtask

    task automatic queue_xy(logic [COORD_W-1:0] x, logic [COORD_W-1:0] y, logic restart);
        point_t p;
        p.x = x;
        p.y = y;
        p.restart = restart;
        queue_point(p);
    endtask

    // Mostly points placed around earlier ones, so that matches, near misses and
    // the exact radius boundary come up often.
    task automatic add_random_point();
        point_t p;
        point_t b;
        int     sel;
        int     r;
        int     off;
        int     wide;
        r = int'(radius);
        wide = 3 * r + 4;
        p.restart = (since_restart >= 40) || ($urandom_range(0, 15) == 0);
        sel = $urandom_range(0, 9);
        if (hist_n == 0 || sel < 2)
        begin
            p.x = COORD_W'($urandom);
            p.y = COORD_W'($urandom);
        end
        else
        begin
            b = hist[$urandom_range(0, hist_n - 1)];
            p.x = b.x;
            p.y = b.y;
            if (sel >= 3 && sel <= 5)
            begin
                p.x = b.x + COORD_W'(int'($urandom_range(0, 2 * r)) - r);
                p.y = b.y + COORD_W'(int'($urandom_range(0, 2 * r)) - r);
            end
            else if (sel >= 6 && sel <= 7)
            begin
                off = r + int'($urandom_range(0, 2)) - 1;
                if ($urandom_range(0, 1))
                    off = -off;
                if ($urandom_range(0, 1))
                    p.x = b.x + COORD_W'(off);
                else
                    p.y = b.y + COORD_W'(off);
            end
            else if (sel >= 8)
            begin
                p.x = b.x + COORD_W'(int'($urandom_range(0, 2 * wide)) - wide);
                p.y = b.y + COORD_W'(int'($urandom_range(0, 2 * wide)) - wide);
            end
        end
        queue_point(p);
    endtask

    // Checked at the falling edge so that every beat of the current cycle has settled.
    task automatic wait_drained();
        while (point_q.size() != 0 || s_tvalid || node_q.size() != 0)
            @(negedge clk);
    endtask

    task automatic write_radius(logic [TOL_W-1:0] value);
        wait_drained();
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        radius = value;
    endtask

    // Point driver.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata <= '0;
            s_tuser <= 1'b0;
        end
        else
        begin
            if (s_tvalid && s_tready)
                node_q.push_back(weld_point(bus_pt));
            if (!s_tvalid || s_tready)
            begin
                if (send_gap > 0)
                begin
                    send_gap--;
                    s_tvalid <= 1'b0;
                end
                else if (idle_en && point_q.size() != 0 && $urandom_range(0, 9) == 0)
                begin
                    send_gap = $urandom_range(0, 11);
                    s_tvalid <= 1'b0;
                end
                else if (point_q.size() != 0)
                begin
                    bus_pt = point_q.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata <= {bus_pt.y, bus_pt.x};
                    s_tuser <= bus_pt.restart;
                end
                else
                    s_tvalid <= 1'b0;
            end
        end
    end

    // Result monitor.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_tready <= 1'b0;
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (node_q.size() == 0)
                begin
                    $display("%0t: unexpected result beat: expected none, got node_id %0d %b",
                             $time, m_tdata, m_tuser);
                    errors++;
                end
                else
                begin
                    want = node_q.pop_front();
                    if (m_tdata !== {{(ID_PAD_W-ID_W){1'b0}}, want.node_id})
                    begin
                        $display("%0t: node_id mismatch: expected %0d, got %0d",
                                 $time, want.node_id, m_tdata);
                        errors++;
                    end
                    if (m_tuser[0] !== want.is_new)
                    begin
                        $display("%0t: is_new mismatch: expected %b, got %b",
                                 $time, want.is_new, m_tuser[0]);
                        errors++;
                    end
                    if (m_tuser[1] !== want.table_full)
                    begin
                        $display("%0t: table_full mismatch: expected %b, got %b",
                                 $time, want.table_full, m_tuser[1]);
                        errors++;
                    end
                end
            end
            if (stall_cnt > 0)
            begin
                stall_cnt--;
                m_tready <= 1'b0;
            end
            else if (idle_en && $urandom_range(0, 7) == 0)
            begin
                stall_cnt = $urandom_range(0, 11);
                m_tready <= 1'b0;
            end
            else
                m_tready <= 1'b1;
        end
    end

    // Watchdog on cycles without any beat.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
                quiet = 0;
            else
                quiet++;
            if (quiet == QUIET_LIMIT)
            begin
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end

    initial
    begin
        point_t           first_pt;
        point_t           last_pt;
        logic [TOL_W-1:0] r;
        int               i;
        int               ph;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // Directed points at the reset radius: just inside and exactly on the radius,
        // newest-first choice, coordinate extremes, all-ones bits and restart.
        queue_xy(24'd0, 24'd0, 1'b0);
        queue_xy(24'd65, 24'd0, 1'b0);
        queue_xy(24'd66, 24'd0, 1'b0);
        queue_xy(24'd46, 24'd46, 1'b0);
        queue_xy(C_MAX, C_MAX, 1'b0);
        queue_xy(C_MIN, C_MIN, 1'b0);
        queue_xy(C_MIN, C_MAX, 1'b0);
        queue_xy(C_MAX, C_MIN, 1'b0);
        queue_xy(C_MAX - 24'd40, C_MAX - 24'd40, 1'b0);
        queue_xy('1, '1, 1'b0);
        queue_xy(C_MAX, C_MAX, 1'b1);
        queue_xy(C_MIN, C_MIN, 1'b0);

        // A zero radius never welds, not even identical points.
        write_radius('0);
        queue_xy(24'd5, 24'd5, 1'b1);
        queue_xy(24'd5, 24'd5, 1'b0);

        // Largest radius: the squared sums exceed 46 bits and must not wrap.
        write_radius(RADIUS_MAX);
        queue_xy(C_MIN, C_MIN, 1'b1);
        queue_xy(C_MAX, C_MAX, 1'b0);
        queue_xy(24'd0, 24'd0, 1'b0);
        queue_xy(C_MAX, 24'd0, 1'b0);
        queue_xy(C_MAX - 24'd1, 24'd0, 1'b0);

        // Fill the whole table, then overflow it.
        write_radius('0);
        for (i = 0; i < NODE_CAP; i++)
        begin
            queue_xy(COORD_W'($urandom), COORD_W'($urandom), i == 0);
            if (i == 0)
                first_pt = point_q[$];
            last_pt = point_q[$];
        end
        for (i = 0; i < 3; i++)
            queue_xy(COORD_W'($urandom), COORD_W'($urandom), 1'b0);
        write_radius(RADIUS_AT_RESET);
        queue_xy(last_pt.x, last_pt.y, 1'b0);
        queue_xy(first_pt.x, first_pt.y, 1'b0);
        queue_xy(COORD_W'($urandom), COORD_W'($urandom), 1'b0);
        since_restart = 40;

        for (ph = 0; ph < RANDOM_PHASES; ph++)
        begin
            case (ph)
                0: r = TOL_W'($urandom_range(1, 200));
                1: r = RADIUS_AT_RESET;
                2: r = '0;
                3: r = RADIUS_MAX;
                4: r = TOL_W'($urandom_range(1000, 200000));
                default: r = TOL_W'($urandom);
            endcase
            if (ph == RANDOM_PHASES - 1)
                idle_en = 1'b0;
            write_radius(r);
            for (i = 0; i < PHASE_POINTS; i++)
            begin
                // Hold the points back once until the block has answered everything.
                if (ph == 2 && i == PHASE_POINTS / 2)
                    wait_drained();
                add_random_point();
            end
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (errors == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

/* sim.f */
hdl/tpd_pkg.sv
hdl/tpd_mem.sv
hdl/tpd_dist.sv
hdl/tolerant_point_dedup_top.sv
tb/sv/tb_tolerant_point_dedup_top.sv
